FILE: design/pse_pkg.sv
// ============================================================================
// pse_pkg: shared types and constants of the planar speed estimator
// Field widths, register reset values, target kind codes and the request and
// response records of the shared serial divider.
// ============================================================================
package pse_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int TICK_W  = 32;
    localparam int ID_W    = 32;
    localparam int KIND_W  = 3;
    localparam int SPEED_W = 32;

    // datapath widths
    localparam int DIFF_W  = POS_W + 1;          // magnitude of a coordinate difference
    localparam int SQ_W    = 2 * DIFF_W;         // sum of two squares
    localparam int ROOT_W  = DIFF_W;             // floor square root
    localparam int SREM_W  = ROOT_W + 1;         // square root partial remainder
    localparam int PROD_W  = ROOT_W + TICK_W;    // distance times tick rate
    localparam int SUM_W   = 40;                 // running sum of the window
    localparam int DQ_W    = 40;                 // divider dividend and quotient
    localparam int STEP_W  = 6;                  // step counter

    // configuration register indexes
    localparam logic CFG_TPS = 1'b0;
    localparam logic CFG_MIN = 1'b1;

    // configuration reset values
    localparam logic [TICK_W-1:0] TPS_RESET = 32'd10000000;
    localparam logic [TICK_W-1:0] MIN_RESET = 32'd1000;

    // target kind codes
    localparam logic [KIND_W-1:0] KIND_DEFAULT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ITEM    = 3'd4;

    // serial step counts
    localparam logic [STEP_W-1:0] SQ_MID      = 6'(DIFF_W - 1);
    localparam logic [STEP_W-1:0] SQ_LAST     = 6'(2 * DIFF_W - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST   = 6'(ROOT_W - 1);
    localparam logic [STEP_W-1:0] STEPS_SPEED = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_MEAN  = 6'd40;

    localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

    // request to the serial divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DQ_W-1:0]   dividend;
        logic [31:0]       rem;
        logic [31:0]       divisor;
    } t_div_req;

    // response of the serial divider
    typedef struct packed {
        logic            done;
        logic [DQ_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: design/pse_sdiv.sv
// ============================================================================
// pse_sdiv: bit-serial restoring divider
// One quotient bit per cycle. The remainder may start preloaded so that only
// the low dividend bits are walked; the quotient shifts in at the bottom.
// ============================================================================
module pse_sdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pse_pkg::t_div_req  i_req,
    output pse_pkg::t_div_rsp  o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [pse_pkg::STEP_W-1:0] r_cnt;
    logic [31:0]                r_rem;
    logic [31:0]                r_dvs;
    logic [pse_pkg::DQ_W-1:0]   r_dq;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;
    logic [31:0] n_rem;

    // trial subtraction of one step
    assign w_trial = {r_rem, r_dq[pse_pkg::DQ_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];

    // busy and done control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == pse_pkg::STEP_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.steps;
            r_rem <= i_req.rem;
            r_dq  <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - pse_pkg::STEP_W'(1);
            r_rem <= n_rem;
            r_dq  <= {r_dq[pse_pkg::DQ_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (i_req.steps != '0) && (i_req.divisor != '0))
        else $error("divider started with no steps or zero divisor");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

FILE: design/planar_speed_estimator_unit.sv
// ============================================================================
// planar_speed_estimator_unit: X/Z speed with moving average and peak hold
// Per item: target check, squared distance, floor square root, scaling by
// the tick rate, division by elapsed ticks, window ring update and mean.
// ============================================================================
//
//  channel   direction  handshake                    contents
//  in        sink       i_in_valid / o_in_ready      position, ticks, target, reset flag
//  out       source     o_out_valid / i_out_ready    current and peak speed
//  cfg       sink       i_cfg_we                     tick rate, minimum elapsed ticks
//
//  An item that takes a speed sample runs through shift-add squaring,
//  square root, shift-add scaling, serial speed division (skipped when
//  the speed saturates) and serial mean division, one bit per cycle each.
//  An item that takes no sample goes straight to the final state.
//  Synchronous active-low reset clears all tracking; the ring holds no reset.
//  A new item is accepted while the previous result still waits on the output
//  register; a stalled output holds the next result in the final state.
//
module planar_speed_estimator_unit #(
    parameter int WINDOW = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pse_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [pse_pkg::POS_W-1:0]  i_pos_z,
    input  logic                              i_pos_valid,
    input  logic [pse_pkg::TICK_W-1:0]        i_elapsed_ticks,
    input  logic [pse_pkg::ID_W-1:0]          i_target_id,
    input  logic [pse_pkg::KIND_W-1:0]        i_target_kind,
    input  logic                              i_manual_reset,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pse_pkg::SPEED_W-1:0]       o_current_speed,
    output logic [pse_pkg::SPEED_W-1:0]       o_peak_speed,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [pse_pkg::TICK_W-1:0]        i_cfg_data
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SQ   = 11'b000_0000_0010,
        S_SQRT = 11'b000_0000_0100,
        S_MUL  = 11'b000_0000_1000,
        S_SATC = 11'b000_0001_0000,
        S_DIVS = 11'b000_0010_0000,
        S_RD   = 11'b000_0100_0000,
        S_UPD  = 11'b000_1000_0000,
        S_MEAN = 11'b001_0000_0000,
        S_DIVM = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // architectural state
    logic [pse_pkg::TICK_W-1:0]         r_tps;
    logic [pse_pkg::TICK_W-1:0]         r_min;
    logic [IW-1:0]                      r_idx;
    logic                               r_full;
    logic [pse_pkg::SUM_W-1:0]          r_sum;
    logic                               r_have;
    logic signed [pse_pkg::POS_W-1:0]   r_last_x;
    logic signed [pse_pkg::POS_W-1:0]   r_last_z;
    logic [pse_pkg::SPEED_W-1:0]        r_mean;
    logic [pse_pkg::SPEED_W-1:0]        r_peak;
    logic [pse_pkg::ID_W-1:0]           r_tid;
    logic [pse_pkg::KIND_W-1:0]         r_tkind;
    logic                               r_o_valid;

    // working registers
    logic [pse_pkg::STEP_W-1:0]         r_cnt;
    logic [pse_pkg::SQ_W-1:0]           r_acc;
    logic [pse_pkg::SQ_W-1:0]           r_mcand;
    logic [pse_pkg::DIFF_W-1:0]         r_mplr;
    logic [pse_pkg::DIFF_W-1:0]         r_dz_mag;
    logic [pse_pkg::TICK_W-1:0]         r_elapsed;
    logic                               r_manual;
    logic [pse_pkg::ROOT_W-1:0]         r_root;
    logic [pse_pkg::SREM_W-1:0]         r_srem;
    logic [pse_pkg::PROD_W-1:0]         r_prod;
    logic [pse_pkg::SPEED_W-1:0]        r_inst;
    logic [pse_pkg::SPEED_W-1:0]        r_ring_rd;
    logic [pse_pkg::SPEED_W-1:0]        r_cur_o;
    logic [pse_pkg::SPEED_W-1:0]        r_peak_o;

    // speed ring
    logic [pse_pkg::SPEED_W-1:0]        r_ring [WINDOW];

    logic                               w_in_fire;
    logic                               w_fin_fire;
    logic                               w_self;
    logic [pse_pkg::ID_W-1:0]           w_nid;
    logic [pse_pkg::KIND_W-1:0]         w_nkind;
    logic                               w_changed;
    logic                               w_sample;
    logic signed [pse_pkg::DIFF_W-1:0]  w_dx;
    logic signed [pse_pkg::DIFF_W-1:0]  w_dz;
    logic [pse_pkg::DIFF_W-1:0]         w_dx_mag;
    logic [pse_pkg::DIFF_W-1:0]         w_dz_mag;
    logic [pse_pkg::SREM_W+1:0]         w_sq_t;
    logic [pse_pkg::SREM_W+1:0]         w_sq_trial;
    logic                               w_sq_ge;
    logic [pse_pkg::SREM_W+1:0]         w_sq_diff;
    logic [pse_pkg::SREM_W-1:0]         n_srem;
    logic [pse_pkg::ROOT_W-1:0]         n_root;
    logic [pse_pkg::TICK_W:0]           w_mul_hi;
    logic                               w_sat;
    logic [CW-1:0]                      w_count;
    pse_pkg::t_div_req                  w_div_req;
    pse_pkg::t_div_rsp                  w_div_rsp;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_fin_fire = (r_state == S_FIN) && (!r_o_valid || i_out_ready);

    // target normalisation and change check
    assign w_self    = (i_target_id == '0) || (i_target_kind == pse_pkg::KIND_DEFAULT) ||
                       (i_target_kind >= pse_pkg::KIND_ITEM);
    assign w_nid     = w_self ? '0 : i_target_id;
    assign w_nkind   = w_self ? pse_pkg::KIND_DEFAULT : i_target_kind;
    assign w_changed = (w_nid != r_tid) || (w_nkind != r_tkind);
    assign w_sample  = i_pos_valid && !w_changed && r_have && (i_elapsed_ticks > r_min);

    // coordinate difference magnitudes
    assign w_dx     = {i_pos_x[pse_pkg::POS_W-1], i_pos_x} - {r_last_x[pse_pkg::POS_W-1], r_last_x};
    assign w_dz     = {i_pos_z[pse_pkg::POS_W-1], i_pos_z} - {r_last_z[pse_pkg::POS_W-1], r_last_z};
    assign w_dx_mag = w_dx[pse_pkg::DIFF_W-1] ? (~w_dx + 1'b1) : w_dx;
    assign w_dz_mag = w_dz[pse_pkg::DIFF_W-1] ? (~w_dz + 1'b1) : w_dz;

    // one square root digit: bring down two radicand bits
    assign w_sq_t     = {r_srem, r_acc[pse_pkg::SQ_W-1 -: 2]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);
    assign w_sq_diff  = w_sq_t - w_sq_trial;
    assign n_srem     = w_sq_ge ? w_sq_diff[pse_pkg::SREM_W-1:0] : w_sq_t[pse_pkg::SREM_W-1:0];
    assign n_root     = {r_root[pse_pkg::ROOT_W-2:0], w_sq_ge};

    // one shift-add step of distance times tick rate
    assign w_mul_hi = {1'b0, r_prod[pse_pkg::PROD_W-1 -: pse_pkg::TICK_W]} +
                      (r_prod[0] ? {1'b0, r_tps} : '0);

    // quotient would not fit in 32 bits
    assign w_sat = ({7'b0, r_prod[pse_pkg::PROD_W-1:32]} >= r_elapsed);

    // filled entries of the window
    assign w_count = r_full ? CW'(WINDOW) : CW'(r_idx);

    // divider requests: speed from the product, mean from the running sum
    always_comb begin
        w_div_req.start = ((r_state == S_SATC) && !w_sat) || (r_state == S_MEAN);
        if (r_state == S_MEAN) begin
            w_div_req.steps    = pse_pkg::STEPS_MEAN;
            w_div_req.dividend = r_sum;
            w_div_req.rem      = '0;
            w_div_req.divisor  = 32'(w_count);
        end else begin
            w_div_req.steps    = pse_pkg::STEPS_SPEED;
            w_div_req.dividend = {r_prod[31:0], 8'b0};
            w_div_req.rem      = 32'(r_prod[pse_pkg::PROD_W-1:32]);
            w_div_req.divisor  = r_elapsed;
        end
    end

    pse_sdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_fire) n_state = w_sample ? S_SQ : S_FIN;
            S_SQ:   if (r_cnt == pse_pkg::SQ_LAST) n_state = S_SQRT;
            S_SQRT: if (r_cnt == pse_pkg::ROOT_LAST) n_state = S_MUL;
            S_MUL:  if (r_cnt == pse_pkg::ROOT_LAST) n_state = S_SATC;
            S_SATC: n_state = w_sat ? S_RD : S_DIVS;
            S_DIVS: if (w_div_rsp.done) n_state = S_RD;
            S_RD:   n_state = S_UPD;
            S_UPD:  n_state = S_MEAN;
            S_MEAN: n_state = S_DIVM;
            S_DIVM: if (w_div_rsp.done) n_state = S_FIN;
            S_FIN:  if (w_fin_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_tps     <= pse_pkg::TPS_RESET;
            r_min     <= pse_pkg::MIN_RESET;
            r_idx     <= '0;
            r_full    <= 1'b0;
            r_sum     <= '0;
            r_have    <= 1'b0;
            r_last_x  <= '0;
            r_last_z  <= '0;
            r_mean    <= '0;
            r_peak    <= '0;
            r_tid     <= '0;
            r_tkind   <= pse_pkg::KIND_DEFAULT;
        end else begin
            r_state <= n_state;

            // output register occupancy
            if (o_out_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_fin_fire) begin
                r_o_valid <= 1'b1;
            end

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pse_pkg::CFG_TPS: r_tps <= i_cfg_data;
                    pse_pkg::CFG_MIN: r_min <= i_cfg_data;
                    default: ;
                endcase
            end

            // accepted transaction: target change and last position
            if (w_in_fire) begin
                if (w_changed) begin
                    r_idx    <= '0;
                    r_full   <= 1'b0;
                    r_sum    <= '0;
                    r_have   <= 1'b0;
                    r_last_x <= '0;
                    r_last_z <= '0;
                    r_mean   <= '0;
                    r_tid    <= w_nid;
                    r_tkind  <= w_nkind;
                end
                if (i_pos_valid) begin
                    r_have   <= 1'b1;
                    r_last_x <= i_pos_x;
                    r_last_z <= i_pos_z;
                end
            end

            // running sum gains the new speed
            if (r_state == S_RD) begin
                r_sum <= r_sum + pse_pkg::SUM_W'(r_inst);
            end

            // running sum loses the replaced entry, ring pointer advances
            if (r_state == S_UPD) begin
                r_sum <= r_sum - (r_full ? pse_pkg::SUM_W'(r_ring_rd) : '0);
                if (r_idx == IW'(WINDOW - 1)) begin
                    r_idx  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            // new mean and peak hold
            if ((r_state == S_DIVM) && w_div_rsp.done) begin
                r_mean <= w_div_rsp.quot[pse_pkg::SPEED_W-1:0];
                if (w_div_rsp.quot[pse_pkg::SPEED_W-1:0] > r_peak) begin
                    r_peak <= w_div_rsp.quot[pse_pkg::SPEED_W-1:0];
                end
            end

            // manual reset as the result is registered; the result keeps the old values
            if (w_fin_fire && r_manual) begin
                r_idx    <= '0;
                r_full   <= 1'b0;
                r_sum    <= '0;
                r_have   <= 1'b0;
                r_last_x <= '0;
                r_last_z <= '0;
                r_mean   <= '0;
                r_peak   <= '0;
                r_tid    <= '0;
                r_tkind  <= pse_pkg::KIND_DEFAULT;
            end
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_acc     <= '0;
            r_mcand   <= pse_pkg::SQ_W'(w_dx_mag);
            r_mplr    <= w_dx_mag;
            r_dz_mag  <= w_dz_mag;
            r_cnt     <= '0;
            r_elapsed <= i_elapsed_ticks;
            r_manual  <= i_manual_reset;
        end

        // shift-add squaring, dx then dz into one accumulator
        if (r_state == S_SQ) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            if (r_cnt == pse_pkg::SQ_MID) begin
                r_mplr  <= r_dz_mag;
                r_mcand <= pse_pkg::SQ_W'(r_dz_mag);
            end else begin
                r_mplr  <= r_mplr >> 1;
                r_mcand <= r_mcand << 1;
            end
            if (r_cnt == pse_pkg::SQ_LAST) begin
                r_cnt  <= '0;
                r_root <= '0;
                r_srem <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end

        // floor square root, one result bit per cycle
        if (r_state == S_SQRT) begin
            r_acc  <= r_acc << 2;
            r_root <= n_root;
            r_srem <= n_srem;
            if (r_cnt == pse_pkg::ROOT_LAST) begin
                r_cnt  <= '0;
                r_prod <= pse_pkg::PROD_W'(n_root);
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end

        // distance times tick rate, product shifts right
        if (r_state == S_MUL) begin
            r_prod <= {w_mul_hi, r_prod[pse_pkg::ROOT_W-1:1]};
            r_cnt  <= r_cnt + 1'b1;
        end

        // saturated or divided instant speed
        if ((r_state == S_SATC) && w_sat) begin
            r_inst <= pse_pkg::SPEED_SAT;
        end
        if ((r_state == S_DIVS) && w_div_rsp.done) begin
            r_inst <= w_div_rsp.quot[pse_pkg::SPEED_W-1:0];
        end

        // result register
        if (w_fin_fire) begin
            r_cur_o  <= r_mean;
            r_peak_o <= r_peak;
        end
    end

    // ring memory: registered read, single write
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_ring_rd <= r_ring[r_idx];
        end
        if (r_state == S_UPD) begin
            r_ring[r_idx] <= r_inst;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_current_speed = r_cur_o;
    assign o_peak_speed    = r_peak_o;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(WINDOW - 1))
        else $error("ring pointer out of range");
    a_mean_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mean <= r_peak)
        else $error("mean speed above peak hold");
    a_no_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_last_x == '0) && (r_last_z == '0))
        else $error("last position kept without a valid mark");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIVS) || (r_state == S_DIVM))
        else $error("divider result outside a wait state");
`endif

endmodule
